@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the SM3 checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sm3_pkg.sv @@
// ---------------------------------------------------------------------------
// SM3 package
// Types, constants and word functions shared by the SM3 engine modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sm3_pkg;

	typedef logic [31:0]       word_t;
	typedef logic [7:0][31:0]  chain_t;
	typedef logic [15:0][31:0] block_t;

	// Commands from the sequencer to the compression unit.
	typedef struct packed {
		logic start;
		logic init;
	} comp_cmd_t;

	localparam word_t SM3_T_LOW  = 32'h79cc4519;
	localparam word_t SM3_T_HIGH = 32'h7a879d8a;

	localparam chain_t SM3_IV = {
		32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
		32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
	};

	localparam word_t SM3_MARK_WORD = 32'h80000000;

	function automatic word_t rotl(input word_t x, input logic [4:0] n);
		logic [63:0] d;
		d = {x, x} << n;
		return d[63:32];
	endfunction

	function automatic word_t perm0(input word_t x);
		return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
	endfunction

	function automatic word_t perm1(input word_t x);
		return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
	endfunction

	// Round constant rotated by the round number modulo 32.
	function automatic word_t t_rot(input logic [5:0] j);
		word_t t;
		t = (j[5:4] == 2'b00) ? SM3_T_LOW : SM3_T_HIGH;
		return rotl(t, j[4:0]);
	endfunction

endpackage

`default_nettype wire

@@ rtl/sm3_hash_engine.sv @@
// A word that neither completes a block nor ends the message keeps in_ready high.
// A word that completes a block starts a compression, busy until it ends.
// A last item adds padding words at one a cycle, one or two compressions, then
// eight digest words at one a cycle unless stalled; 64 rounds set the rate.
// Reset restores the initial chaining value and clears the fill and length.
// ---------------------------------------------------------------------------
// SM3 hash engine
// Gathers message words into blocks, applies the padding on the last item
// and streams out the eight digest words.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sm3_hash_engine (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire sm3_pkg::word_t     data_word,
	input  wire logic [2:0]         valid_bytes,
	input  wire logic               last_item,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      sm3_pkg::word_t     digest_word,
	output      logic               last_word
);
	import sm3_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PAD  = 4'b0010,
		ST_COMP = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	typedef enum logic [3:0] {
		PH_MARK = 4'b0001,
		PH_ZERO = 4'b0010,
		PH_LLO  = 4'b0100,
		PH_DONE = 4'b1000
	} phase_t;

	state_t      state_q;
	phase_t      phase_q;
	logic        final_q;
	logic [3:0]  fill_q;
	logic [63:0] bitlen_q;
	block_t      blk_q;
	logic        start_q;
	logic [2:0]  out_idx_q;

	comp_cmd_t   cmd;
	chain_t      chain;
	logic        comp_done;

	logic        in_acc;
	logic        out_acc;
	logic [2:0]  k_eff;
	word_t       pad_word;
	logic        push_en;
	word_t       push_word;

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = (state_q == ST_OUT);
	assign in_acc      = in_valid && in_ready;
	assign out_acc     = out_valid && out_ready;
	assign digest_word = chain[out_idx_q];
	assign last_word   = (out_idx_q == 3'd7);

	assign cmd.start = start_q;
	assign cmd.init  = out_acc && last_word;

	// Byte count of the item: a full word unless the last item says fewer.
	assign k_eff = (!last_item || valid_bytes > 3'd4) ? 3'd4 : valid_bytes;

	// Short last word with the marker byte placed after its message bytes.
	always_comb begin
		case (k_eff[1:0])
			2'd1:    pad_word = {data_word[31:24], 24'h800000};
			2'd2:    pad_word = {data_word[31:16], 16'h8000};
			2'd3:    pad_word = {data_word[31:8], 8'h80};
			default: pad_word = SM3_MARK_WORD;
		endcase
	end

	// Word pushed into the block this cycle, from the input or the padding.
	always_comb begin
		push_en   = 1'b0;
		push_word = '0;
		if (in_acc) begin
			push_en   = 1'b1;
			push_word = (k_eff == 3'd4) ? data_word : pad_word;
		end else if (state_q == ST_PAD) begin
			push_en = 1'b1;
			case (phase_q)
				PH_MARK: push_word = SM3_MARK_WORD;
				PH_ZERO: push_word = (fill_q == 4'd14) ? bitlen_q[63:32] : '0;
				PH_LLO:  push_word = bitlen_q[31:0];
				default: push_word = '0;
			endcase
		end
	end

	// Block buffer.
	always_ff @(posedge clk) begin
		if (push_en) begin
			blk_q[fill_q] <= push_word;
		end
	end

	// Sequencer for input, padding, compression and output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			phase_q   <= PH_MARK;
			final_q   <= 1'b0;
			fill_q    <= '0;
			bitlen_q  <= '0;
			start_q   <= 1'b0;
			out_idx_q <= '0;
		end else begin
			start_q <= 1'b0;
			if (push_en) begin
				fill_q <= fill_q + 4'd1;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						bitlen_q <= bitlen_q + {58'd0, k_eff, 3'b000};
						final_q  <= last_item;
						phase_q  <= (k_eff == 3'd4) ? PH_MARK : PH_ZERO;
						if (fill_q == 4'd15) begin
							state_q <= ST_COMP;
							start_q <= 1'b1;
						end else if (last_item) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					case (phase_q)
						PH_MARK: phase_q <= PH_ZERO;
						PH_ZERO: phase_q <= (fill_q == 4'd14) ? PH_LLO : PH_ZERO;
						PH_LLO:  phase_q <= PH_DONE;
						default: phase_q <= PH_DONE;
					endcase
					if (fill_q == 4'd15) begin
						state_q <= ST_COMP;
						start_q <= 1'b1;
					end
				end
				ST_COMP: begin
					if (comp_done) begin
						if (!final_q) begin
							state_q <= ST_IDLE;
						end else if (phase_q == PH_DONE) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_OUT: begin
					if (out_acc) begin
						out_idx_q <= out_idx_q + 3'd1;
						if (last_word) begin
							state_q  <= ST_IDLE;
							final_q  <= 1'b0;
							fill_q   <= '0;
							bitlen_q <= '0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	sm3_round_core u_compress (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.block (blk_q),
		.chain (chain),
		.done  (comp_done)
	);

endmodule

`default_nettype wire

@@ rtl/sm3_compress.sv @@
// ---------------------------------------------------------------------------
// SM3 compression unit
// One round per cycle over a 16-word expansion window, 64 rounds per block,
// then the working registers are folded into the chaining value.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sm3_round_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire sm3_pkg::comp_cmd_t cmd,
	input  wire sm3_pkg::block_t   block,
	output      sm3_pkg::chain_t   chain,
	output      logic              done
);
	import sm3_pkg::*;

	block_t     win_q;
	chain_t     work_q;
	chain_t     chain_q;
	logic [5:0] round_q;
	logic       run_q;
	logic       fin_q;

	word_t a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
	word_t a, b, c, d, e, f, g, h;

	assign chain = chain_q;
	assign done  = fin_q;

	always_comb begin
		a = work_q[0]; b = work_q[1]; c = work_q[2]; d = work_q[3];
		e = work_q[4]; f = work_q[5]; g = work_q[6]; h = work_q[7];
	end

	// Round datapath for the current round number.
	always_comb begin
		a12 = rotl(a, 5'd12);
		ss1 = rotl(a12 + e + t_rot(round_q), 5'd7);
		ss2 = ss1 ^ a12;
		if (round_q[5:4] == 2'b00) begin
			ff = a ^ b ^ c;
			gg = e ^ f ^ g;
		end else begin
			ff = (a & b) | (a & c) | (b & c);
			gg = (e & f) | (~e & g);
		end
		tt1 = ff + d + ss2 + (win_q[0] ^ win_q[4]);
		tt2 = gg + h + ss1 + win_q[0];
	end

	// Next expanded word from the window taps.
	assign w_new = perm1(win_q[0] ^ win_q[7] ^ rotl(win_q[13], 5'd15))
		^ rotl(win_q[3], 5'd7) ^ win_q[10];

	// Sequencer for the round loop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			fin_q   <= 1'b0;
			round_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (cmd.start) begin
				run_q   <= 1'b1;
				round_q <= '0;
			end else if (run_q) begin
				round_q <= round_q + 6'd1;
				if (round_q == 6'd63) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	// Chaining value: initial value after reset or on request, folded after a block.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= SM3_IV;
		end else if (cmd.init) begin
			chain_q <= SM3_IV;
		end else if (fin_q) begin
			chain_q <= chain_q ^ work_q;
		end
	end

	// Working registers and expansion window.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			win_q  <= block;
			work_q <= chain_q;
		end else if (run_q) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= w_new;
			work_q[0] <= tt1;
			work_q[1] <= a;
			work_q[2] <= rotl(b, 5'd9);
			work_q[3] <= c;
			work_q[4] <= perm0(tt2);
			work_q[5] <= e;
			work_q[6] <= rotl(f, 5'd19);
			work_q[7] <= g;
		end
	end

endmodule

`default_nettype wire

@@ rtl/sm3_checker.sv @@
// ---------------------------------------------------------------------------
// SM3 port checker
// Watches the top-level ports of the hash engine over time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sm3_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        last_item,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [31:0] digest_word,
	input wire logic        last_word
);

	// The engine never takes input while a digest is being delivered.
	`CHK_IMPLY(a_no_overlap, clk, arst_n, out_valid, !in_ready, "input ready during output")

	// A stalled digest item holds its value.
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(digest_word) && $stable(last_word), "stalled digest changed")

	// An item that is not last causes no output in the next cycle.
	`CHK_NEXT(a_quiet_after_word, clk, arst_n, in_valid && in_ready && !last_item,
		!out_valid, "output after a non-final item")

	// After the final digest word the engine returns to taking input.
	`CHK_NEXT(a_idle_after_digest, clk, arst_n, out_valid && out_ready && last_word,
		!out_valid && in_ready, "engine not idle after final digest word")

endmodule

bind sm3_hash_engine sm3_checker u_sm3_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.last_item  (last_item),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.digest_word(digest_word),
	.last_word  (last_word)
);

`default_nettype wire

@@ tb/sm3_hash_engine_tb.sv @@
// ---------------------------------------------------------------------------
// SM3 hash engine testbench
// Streams messages into the engine and checks every digest word against a
// predictor that hashes the same items. The directed tests cover the padding
// corner cases and a long output hold that stalls the input; the random test
// covers varied lengths and random idling on both channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sm3_hash_engine_tb;

	import sm3_pkg::word_t;

	// Item and run sizing.
	localparam logic [2:0] FULL_WORD      = 3'd4;
	localparam logic [2:0] NO_BYTES       = 3'd0;
	localparam int         TARGET_ITEMS   = 410;
	localparam int         HOLD_CYCLES    = 700;
	localparam int         WATCHDOG_LIMIT = 4000;
	localparam int         TAIL_CYCLES    = 200;

	// Hash constants.
	localparam word_t PAD_MARK = 32'h80000000;
	localparam word_t T_EARLY  = 32'h79cc4519;
	localparam word_t T_LATE   = 32'h7a879d8a;
	localparam logic [7:0][31:0] IV_CHAIN = {
		32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
		32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f
	};

	// Receiver stall patterns.
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_STRIDE
	} rx_mode_t;

	typedef struct packed {
		word_t value;
		logic  is_last;
	} digest_exp_t;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	word_t data_word;
	logic  [2:0] valid_bytes;
	logic  last_item;
	logic  out_valid;
	logic  out_ready;
	word_t digest_word;
	logic  last_word;

	// Predictor state.
	word_t            blk_buf [0:15];
	logic [7:0][31:0] chain_val;
	int               fill_cnt;
	logic [63:0]      msg_bits;
	digest_exp_t      digest_q [$];

	// Run bookkeeping.
	int err_count;
	int items_sent;
	int msgs_hashed;
	int extra_pad_blocks;
	int words_checked;
	int burst_left;
	int stall_cycles;
	bit hold_req;

	sm3_hash_engine i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.data_word   (data_word),
		.valid_bytes (valid_bytes),
		.last_item   (last_item),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digest_word (digest_word),
		.last_word   (last_word)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Digest predictor
	// ------------------------------------------------------------------

	function automatic word_t rotate_left(word_t x, int n);
		int s;
		s = n & 31;
		if (s == 0)
			return x;
		return (x << s) | (x >> (32 - s));
	endfunction

	function automatic word_t diffuse_p0(word_t x);
		return x ^ rotate_left(x, 9) ^ rotate_left(x, 17);
	endfunction

	function automatic word_t diffuse_p1(word_t x);
		return x ^ rotate_left(x, 15) ^ rotate_left(x, 23);
	endfunction

	// Expands the held block and folds 64 rounds into the chaining value.
	function automatic void compress_block();
		word_t w [0:67];
		word_t a, b, c, d, e, f, g, h;
		word_t tj, a12, ss1, ss2, ff, gg, tt1, tt2;
		for (int j = 0; j < 16; j++)
			w[j] = blk_buf[j];
		for (int j = 16; j < 68; j++)
			w[j] = diffuse_p1(w[j-16] ^ w[j-9] ^ rotate_left(w[j-3], 15))
				^ rotate_left(w[j-13], 7) ^ w[j-6];
		{h, g, f, e, d, c, b, a} = chain_val;
		for (int j = 0; j < 64; j++) begin
			tj  = (j < 16) ? T_EARLY : T_LATE;
			a12 = rotate_left(a, 12);
			ss1 = rotate_left(a12 + e + rotate_left(tj, j), 7);
			ss2 = ss1 ^ a12;
			ff  = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
			gg  = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
			tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
			tt2 = gg + h + ss1 + w[j];
			d = c; c = rotate_left(b, 9);  b = a; a = tt1;
			h = g; g = rotate_left(f, 19); f = e; e = diffuse_p0(tt2);
		end
		chain_val = chain_val ^ {h, g, f, e, d, c, b, a};
	endfunction

	function automatic void absorb_word(word_t w);
		blk_buf[fill_cnt] = w;
		fill_cnt++;
		if (fill_cnt == 16) begin
			compress_block();
			fill_cnt = 0;
		end
	endfunction

	function automatic void clear_message();
		chain_val = IV_CHAIN;
		fill_cnt  = 0;
		msg_bits  = '0;
	endfunction

	// Absorbs one accepted item; the last item pads and queues the digest.
	function automatic void predict_digest(word_t data, logic [2:0] vb, logic last);
		int unsigned k;
		word_t       mask;
		digest_exp_t exp_word;
		k = (vb > FULL_WORD || !last) ? 4 : vb;
		msg_bits += 64'(k * 8);
		if (!last) begin
			absorb_word(data);
			return;
		end
		if (k == 4) begin
			absorb_word(data);
			absorb_word(PAD_MARK);
		end else begin
			mask = (k == 0) ? '0 : (32'hffffffff << (32 - 8 * k));
			absorb_word((data & mask) | (32'h80 << (24 - 8 * k)));
		end
		// No room left for the length: pad out an extra block.
		if (fill_cnt > 14) begin
			extra_pad_blocks++;
			while (fill_cnt != 0)
				absorb_word('0);
		end
		while (fill_cnt < 14)
			absorb_word('0);
		absorb_word(msg_bits[63:32]);
		absorb_word(msg_bits[31:0]);
		for (int i = 0; i < 8; i++) begin
			exp_word.value   = chain_val[i];
			exp_word.is_last = (i == 7);
			digest_q.push_back(exp_word);
		end
		msgs_hashed++;
		clear_message();
	endfunction

	// ------------------------------------------------------------------
	// Sender, receiver, checker and watchdog
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, word_t want, word_t got);
		$display("MISMATCH at %0t: %s, expected %08h, got %08h", $realtime, what, want, got);
		err_count++;
	endtask

	// Offers one item from a falling edge and waits for it to be taken.
	// Items go out in bursts with random gaps between them.
	task automatic send_item(word_t data, logic [2:0] vb, logic last);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(20, 90)) @(negedge clk);
			else
				repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_valid    = 1'b1;
		data_word   = data;
		valid_bytes = vb;
		last_item   = last;
		do
			@(posedge clk);
		while (!in_ready);
		predict_digest(data, vb, last);
		items_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	// Receiver: random stall patterns, or a long hold when requested.
	initial begin : receiver
		rx_mode_t mode;
		int       mode_left;
		int       stride_cnt;
		out_ready  = 1'b0;
		mode       = RX_ALWAYS;
		mode_left  = 0;
		stride_cnt = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				stride_cnt++;
				case (mode)
					RX_ALWAYS: out_ready = 1'b1;
					RX_COIN:   out_ready = 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready = ($urandom_range(0, 3) == 0);
					default:   out_ready = (stride_cnt % 3 != 0);
				endcase
			end
		end
	end

	// Each accepted digest word is compared with the oldest expectation.
	always @(posedge clk) begin
		digest_exp_t want;
		if (arst_n && out_valid && out_ready) begin
			if (digest_q.size() == 0) begin
				report_mismatch("digest word with none expected", '0, digest_word);
			end else begin
				want = digest_q.pop_front();
				if (digest_word !== want.value)
					report_mismatch("digest_word", want.value, digest_word);
				if (last_word !== want.is_last)
					report_mismatch("last_word", {31'd0, want.is_last}, {31'd0, last_word});
				words_checked++;
			end
		end
	end

	// Ends the run if neither channel moves an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no item moved for %0d cycles", stall_cycles);
				$display("sm3_hash_engine test failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Empty message; the data bits of an empty last item must be ignored.
	task automatic test_empty_message();
		send_item(32'hffffffff, NO_BYTES, 1'b1);
	endtask

	// One to three bytes on the last item, with junk in the unused bytes.
	task automatic test_partial_last_word();
		send_item(32'h61a5a5a5, 3'd1, 1'b1);
		send_item(32'h61625a5a, 3'd2, 1'b1);
		send_item(32'h616263ff, 3'd3, 1'b1);
	endtask

	// Byte counts above four on the last item count as a full word.
	task automatic test_oversized_count();
		send_item(32'h01234567, 3'd5, 1'b1);
		send_item(32'h89abcdef, 3'd6, 1'b1);
		send_item(32'hfedcba98, 3'd7, 1'b1);
	endtask

	// Short counts on items that are not last still take the whole word.
	task automatic test_short_word_not_last();
		send_item(32'h12345678, 3'd1, 1'b0);
		send_item(32'h9abcdef0, NO_BYTES, 1'b0);
		send_item(32'hdeadbeef, FULL_WORD, 1'b1);
	endtask

	// Fourteen full words leave no room for the length: an extra block.
	task automatic test_extra_pad_block();
		for (int i = 0; i < 13; i++)
			send_item((i % 2 == 0) ? 32'h00000000 : 32'hffffffff, FULL_WORD, 1'b0);
		send_item(32'hffffffff, FULL_WORD, 1'b1);
	endtask

	// Receiver held off while short messages keep arriving.
	task automatic test_output_hold();
		hold_req = 1'b1;
		for (int m = 0; m < 4; m++) begin
			for (int i = 0; i < m; i++)
				send_item($urandom, FULL_WORD, 1'b0);
			send_item($urandom, 3'($urandom_range(0, 4)), 1'b1);
		end
		while (hold_req)
			@(negedge clk);
	endtask

	// Mostly well-formed messages of random length, some with noisy counts.
	task automatic test_random_messages();
		int unsigned n_words;
		int unsigned pick;
		bit          noisy;
		logic [2:0]  vb;
		while (items_sent < TARGET_ITEMS) begin
			pick  = $urandom_range(0, 99);
			noisy = (pick >= 90);
			if (pick < 70)
				n_words = $urandom_range(0, 17);
			else if (pick < 90)
				n_words = $urandom_range(18, 40);
			else
				n_words = $urandom_range(0, 8);
			for (int i = 0; i < n_words; i++) begin
				vb = noisy ? 3'($urandom_range(0, 7)) : FULL_WORD;
				send_item($urandom, vb, 1'b0);
			end
			vb = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
				: 3'($urandom_range(5, 7));
			send_item($urandom, vb, 1'b1);
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		data_word        = '0;
		valid_bytes      = '0;
		last_item        = 1'b0;
		hold_req         = 1'b0;
		err_count        = 0;
		items_sent       = 0;
		msgs_hashed      = 0;
		extra_pad_blocks = 0;
		words_checked    = 0;
		burst_left       = 0;
		stall_cycles     = 0;
		clear_message();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_message();
		test_partial_last_word();
		test_oversized_count();
		test_short_word_not_last();
		test_extra_pad_block();
		test_output_hold();
		test_random_messages();

		in_valid = 1'b0;
		while (digest_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Hashed %0d messages from %0d items, %0d needing an extra padding block.",
			msgs_hashed, items_sent, extra_pad_blocks);
		$display("Checked %0d digest words, %0d mismatches.", words_checked, err_count);
		if (err_count == 0)
			$display("sm3_hash_engine test passed");
		else
			$display("sm3_hash_engine test failed");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/sm3_pkg.sv
rtl/sm3_compress.sv
rtl/sm3_hash_engine.sv
rtl/sm3_checker.sv
tb/sm3_hash_engine_tb.sv
